[hw/rtl/rk4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared types, constants and the stage microcode of the RK4 step unit.
// ----------------------------------------------------------------------------
package rk4_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int NUM_CFG       = 7;
    localparam int CFG_W         = 31;
    localparam int VAL_W         = 32;
    localparam int ADDR_W        = 5;
    localparam int PC_W          = 7;
    localparam int ACC_W         = 36;
    localparam int RF_DEPTH      = 16;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_KA    = 3'd0;
    localparam logic [2:0] REG_KI    = 3'd1;
    localparam logic [2:0] REG_KS    = 3'd2;
    localparam logic [2:0] REG_ALPHA = 3'd3;
    localparam logic [2:0] REG_MU    = 3'd4;
    localparam logic [2:0] REG_LAM   = 3'd5;
    localparam logic [2:0] REG_H     = 3'd6;

    localparam logic [CFG_W-1:0] RST_KA    = 31'd16777216;
    localparam logic [CFG_W-1:0] RST_KI    = 31'd16777216;
    localparam logic [CFG_W-1:0] RST_KS    = 31'd33554432;
    localparam logic [CFG_W-1:0] RST_ALPHA = 31'd50331648;
    localparam logic [CFG_W-1:0] RST_MU    = 31'd16777216;
    localparam logic [CFG_W-1:0] RST_LAM   = 31'd16777216;
    localparam logic [CFG_W-1:0] RST_H     = 31'd335544;

    // Operand / destination codes: below 16 is a scratch slot
    typedef logic [4:0] t_opd;
    localparam t_opd R_NP   = 5'd0;
    localparam t_opd R_SP   = 5'd1;
    localparam t_opd R_K1N  = 5'd2;
    localparam t_opd R_K1S  = 5'd3;
    localparam t_opd R_K2N  = 5'd4;
    localparam t_opd R_K2S  = 5'd5;
    localparam t_opd R_K3N  = 5'd6;
    localparam t_opd R_K3S  = 5'd7;
    localparam t_opd R_K4N  = 5'd8;
    localparam t_opd R_K4S  = 5'd9;
    localparam t_opd R_T0   = 5'd10;
    localparam t_opd R_T1   = 5'd11;
    localparam t_opd R_T2   = 5'd12;
    localparam t_opd R_T3   = 5'd13;
    localparam t_opd R_T4   = 5'd14;
    localparam t_opd C_KA   = 5'd16;
    localparam t_opd C_KI   = 5'd17;
    localparam t_opd C_KS   = 5'd18;
    localparam t_opd C_ALPHA = 5'd19;
    localparam t_opd C_MU   = 5'd20;
    localparam t_opd C_LAM  = 5'd21;
    localparam t_opd C_H    = 5'd22;
    localparam t_opd C_ONE  = 5'd23;
    localparam t_opd C_ZERO = 5'd24;
    localparam t_opd S_N    = 5'd25;
    localparam t_opd S_S    = 5'd26;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_HALF, OP_ACCSET, OP_ACC2, OP_DIV6
    } t_op;

    typedef struct packed {
        t_op  op;
        t_opd dst;
        t_opd a;
        t_opd b;
    } t_instr;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_MULW, ST_DIVRUN, ST_DIVEND, ST_DONE
    } t_state;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    localparam logic [PC_W-1:0] PC_LAST = 7'd83;

    function automatic t_instr mk(t_op op, t_opd dst, t_opd a, t_opd b);
        t_instr w;
        w.op = op; w.dst = dst; w.a = a; w.b = b;
        return w;
    endfunction

    // Evaluate both rates at (NP, SP) into kn, ks
    function automatic t_instr eval_word(logic [3:0] i, t_opd kn, t_opd ks);
        t_instr w;
        unique case (i)
            4'd0:  w = mk(OP_ADD, R_T0, C_KS, R_SP);
            4'd1:  w = mk(OP_DIV, R_T0, R_SP, R_T0);
            4'd2:  w = mk(OP_SUB, kn, R_T0, R_NP);
            4'd3:  w = mk(OP_MUL, R_T1, C_LAM, R_NP);
            4'd4:  w = mk(OP_ADD, R_T1, C_ALPHA, R_T1);
            4'd5:  w = mk(OP_SUB, R_T2, C_ONE, R_SP);
            4'd6:  w = mk(OP_MUL, R_T1, R_T1, R_T2);
            4'd7:  w = mk(OP_ADD, R_T2, C_KI, C_ONE);
            4'd8:  w = mk(OP_SUB, R_T2, R_T2, R_SP);
            4'd9:  w = mk(OP_DIV, R_T1, R_T1, R_T2);
            4'd10: w = mk(OP_MUL, R_T3, C_MU, R_SP);
            4'd11: w = mk(OP_ADD, R_T4, C_KA, R_SP);
            4'd12: w = mk(OP_DIV, R_T3, R_T3, R_T4);
            default: w = mk(OP_SUB, ks, R_T1, R_T3);
        endcase
        return w;
    endfunction

    // Next stage point, halved increments
    function automatic t_instr half_pt_word(logic [2:0] i, t_opd kn, t_opd ks);
        t_instr w;
        unique case (i)
            3'd0: w = mk(OP_MUL, R_T0, C_H, kn);
            3'd1: w = mk(OP_HALF, R_T0, R_T0, C_ZERO);
            3'd2: w = mk(OP_ADD, R_NP, S_N, R_T0);
            3'd3: w = mk(OP_MUL, R_T1, C_H, ks);
            3'd4: w = mk(OP_HALF, R_T1, R_T1, C_ZERO);
            default: w = mk(OP_ADD, R_SP, S_S, R_T1);
        endcase
        return w;
    endfunction

    // Weighted average and state update for one species
    function automatic t_instr comb_word(logic [2:0] i, t_opd k1, t_opd k2, t_opd k3,
                                         t_opd k4, t_opd x);
        t_instr w;
        unique case (i)
            3'd0: w = mk(OP_ACCSET, R_T0, k1, k4);
            3'd1: w = mk(OP_ACC2, R_T0, k2, k3);
            3'd2: w = mk(OP_DIV6, R_T0, C_ZERO, C_ZERO);
            3'd3: w = mk(OP_MUL, R_T0, C_H, R_T0);
            default: w = mk(OP_ADD, x, x, R_T0);
        endcase
        return w;
    endfunction

    function automatic t_instr rom_word(logic [PC_W-1:0] pc);
        t_instr w;
        logic [PC_W-1:0] o;
        o = '0;
        if (pc < 7'd2) begin
            w = (pc[0]) ? mk(OP_ADD, R_SP, S_S, C_ZERO) : mk(OP_ADD, R_NP, S_N, C_ZERO);
        end else if (pc < 7'd16) begin
            o = pc - 7'd2;  w = eval_word(o[3:0], R_K1N, R_K1S);
        end else if (pc < 7'd22) begin
            o = pc - 7'd16; w = half_pt_word(o[2:0], R_K1N, R_K1S);
        end else if (pc < 7'd36) begin
            o = pc - 7'd22; w = eval_word(o[3:0], R_K2N, R_K2S);
        end else if (pc < 7'd42) begin
            o = pc - 7'd36; w = half_pt_word(o[2:0], R_K2N, R_K2S);
        end else if (pc < 7'd56) begin
            o = pc - 7'd42; w = eval_word(o[3:0], R_K3N, R_K3S);
        end else if (pc < 7'd60) begin
            // Full-step point
            o = pc - 7'd56;
            unique case (o[1:0])
                2'd0: w = mk(OP_MUL, R_T0, C_H, R_K3N);
                2'd1: w = mk(OP_ADD, R_NP, S_N, R_T0);
                2'd2: w = mk(OP_MUL, R_T1, C_H, R_K3S);
                default: w = mk(OP_ADD, R_SP, S_S, R_T1);
            endcase
        end else if (pc < 7'd74) begin
            o = pc - 7'd60; w = eval_word(o[3:0], R_K4N, R_K4S);
        end else if (pc < 7'd79) begin
            o = pc - 7'd74; w = comb_word(o[2:0], R_K1N, R_K2N, R_K3N, R_K4N, S_N);
        end else begin
            o = pc - 7'd79; w = comb_word(o[2:0], R_K1S, R_K2S, R_K3S, R_K4S, S_S);
        end
        return w;
    endfunction

    // Saturate a signed 64-bit value to 32 bits
    function automatic t_sat sat_s64(logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd2147483647) begin
            r.ovf = 1'b1; r.val = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r.ovf = 1'b1; r.val = 32'h8000_0000;
        end else begin
            r.ovf = 1'b0; r.val = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/rk4_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4 channel interfaces
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rk4_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] init_n;
    logic [31:0] init_s;
    modport source (output valid, command, init_n, init_s, input ready);
    modport sink   (input valid, command, init_n, init_s, output ready);
endinterface

interface rk4_res_if;
    logic        valid;
    logic        ready;
    logic [30:0] time_now;
    logic [31:0] n_out;
    logic [31:0] s_out;
    logic        math_error;
    modport source (output valid, time_now, n_out, s_out, math_error, input ready);
    modport sink   (input valid, time_now, n_out, s_out, math_error, output ready);
endinterface
`default_nettype wire

[hw/rtl/rk4_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rk4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/rk4_two_species_ode_step_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_two_species_ode_step_unit
// Fourth-order Runge-Kutta stepper for a two-species ODE in signed fixed
// point, run as microcode on one shared add/multiply/divide unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_cmd     in   valid/ready      command, init_n, init_s
//  o_res     out  valid/ready      time_now, n_out, s_out, math_error
//  apb       in   psel/penable     paddr, pwdata -> prdata, pready
//
//  A load goes from idle straight to the done state. A step runs 84
//  microcode words, each fetched and then executed; a multiply adds a
//  write-back state, each of the 12 variable divides runs the bit-serial
//  divider and each of the two divides by six writes back from its end state.
//  i_cmd is ready only in idle; one result register decouples o_res, so a
//  stalled result holds the next command in the done state.
//  Synchronous active-low reset clears state, time and the error flag and loads the configuration reset values.
// ----------------------------------------------------------------------------
module rk4_two_species_ode_step_unit #(
    parameter int FRAC_BITS = rk4_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    rk4_cmd_if.sink                        i_cmd,
    rk4_res_if.source                      o_res,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rk4_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output      logic [31:0]               prdata,
    output      logic                      pready
);
    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int RA = $clog2(rk4_pkg::RF_DEPTH);
    localparam logic [31:0] ONE_VAL = 32'(64'd1 << FRAC_BITS);

    // Configuration registers
    logic [30:0] r_ka, r_ki, r_ks, r_alpha, r_mu, r_lam, r_h;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka    <= rk4_pkg::RST_KA;
            r_ki    <= rk4_pkg::RST_KI;
            r_ks    <= rk4_pkg::RST_KS;
            r_alpha <= rk4_pkg::RST_ALPHA;
            r_mu    <= rk4_pkg::RST_MU;
            r_lam   <= rk4_pkg::RST_LAM;
            r_h     <= rk4_pkg::RST_H;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                rk4_pkg::REG_KA:    r_ka    <= pwdata[30:0];
                rk4_pkg::REG_KI:    r_ki    <= pwdata[30:0];
                rk4_pkg::REG_KS:    r_ks    <= pwdata[30:0];
                rk4_pkg::REG_ALPHA: r_alpha <= pwdata[30:0];
                rk4_pkg::REG_MU:    r_mu    <= pwdata[30:0];
                rk4_pkg::REG_LAM:   r_lam   <= pwdata[30:0];
                rk4_pkg::REG_H:     r_h     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rk4_pkg::REG_KA:    prdata = {1'b0, r_ka};
            rk4_pkg::REG_KI:    prdata = {1'b0, r_ki};
            rk4_pkg::REG_KS:    prdata = {1'b0, r_ks};
            rk4_pkg::REG_ALPHA: prdata = {1'b0, r_alpha};
            rk4_pkg::REG_MU:    prdata = {1'b0, r_mu};
            rk4_pkg::REG_LAM:   prdata = {1'b0, r_lam};
            rk4_pkg::REG_H:     prdata = {1'b0, r_h};
            default:            prdata = '0;
        endcase
    end

    // Control and datapath registers
    rk4_pkg::t_state r_state, n_state;
    logic [rk4_pkg::PC_W-1:0] r_pc;
    logic [31:0]  r_n, r_s;
    logic [30:0]  r_time;
    logic         r_err;
    logic signed [63:0] r_prod;
    logic signed [rk4_pkg::ACC_W-1:0] r_acc;
    logic [DW-1:0] r_num;
    logic [31:0]  r_den, r_rem;
    logic         r_neg;
    logic [CW-1:0] r_cnt;
    logic         r_out_valid;
    logic [30:0]  r_out_time;
    logic [31:0]  r_out_n, r_out_s;
    logic         r_out_err;

    rk4_pkg::t_instr w_ins;
    assign w_ins = rk4_pkg::rom_word(r_pc);

    // Scratch register file, duplicated for two read ports
    logic [31:0] w_rd_a, w_rd_b, w_wval;
    logic        w_wen, w_ovf;

    rk4_ram #(.WIDTH(32), .DEPTH(rk4_pkg::RF_DEPTH)) u_rf_a (
        .i_clk(i_clk), .i_we(w_wen && !w_ins.dst[4]), .i_waddr(w_ins.dst[RA-1:0]),
        .i_wdata(w_wval), .i_raddr(w_ins.a[RA-1:0]), .o_rdata(w_rd_a)
    );
    rk4_ram #(.WIDTH(32), .DEPTH(rk4_pkg::RF_DEPTH)) u_rf_b (
        .i_clk(i_clk), .i_we(w_wen && !w_ins.dst[4]), .i_waddr(w_ins.dst[RA-1:0]),
        .i_wdata(w_wval), .i_raddr(w_ins.b[RA-1:0]), .o_rdata(w_rd_b)
    );

    // Operand select
    function automatic logic [31:0] opd_val(rk4_pkg::t_opd c, logic [31:0] rf);
        logic [31:0] v;
        case (c)
            rk4_pkg::C_KA:    v = {1'b0, r_ka};
            rk4_pkg::C_KI:    v = {1'b0, r_ki};
            rk4_pkg::C_KS:    v = {1'b0, r_ks};
            rk4_pkg::C_ALPHA: v = {1'b0, r_alpha};
            rk4_pkg::C_MU:    v = {1'b0, r_mu};
            rk4_pkg::C_LAM:   v = {1'b0, r_lam};
            rk4_pkg::C_H:     v = {1'b0, r_h};
            rk4_pkg::C_ONE:   v = ONE_VAL;
            rk4_pkg::C_ZERO:  v = '0;
            rk4_pkg::S_N:     v = r_n;
            rk4_pkg::S_S:     v = r_s;
            default:          v = rf;
        endcase
        return v;
    endfunction

    logic [31:0] w_a, w_b;
    logic signed [63:0] w_a64, w_b64;
    logic signed [rk4_pkg::ACC_W-1:0] w_pair;
    rk4_pkg::t_sat w_sum, w_dif, w_mulr;
    logic [31:0] w_abs_a, w_abs_b;
    logic [rk4_pkg::ACC_W-1:0] w_abs_acc;
    logic [32:0] w_half_acc;
    logic [18:0] w_lo_sum;
    logic [37:0] w_lo_prod;
    logic [31:0] w_q6;
    logic [32:0] w_rem_sh;
    logic        w_ge;
    logic        w_accept, w_out_load;

    assign w_a     = opd_val(w_ins.a, w_rd_a);
    assign w_b     = opd_val(w_ins.b, w_rd_b);
    assign w_a64   = {{32{w_a[31]}}, w_a};
    assign w_b64   = {{32{w_b[31]}}, w_b};
    assign w_pair  = rk4_pkg::ACC_W'(w_a64 + w_b64);
    assign w_sum   = rk4_pkg::sat_s64(w_a64 + w_b64);
    assign w_dif   = rk4_pkg::sat_s64(w_a64 - w_b64);
    assign w_mulr  = rk4_pkg::sat_s64(r_prod >>> FRAC_BITS);
    assign w_abs_a = w_a[31] ? (~w_a + 32'd1) : w_a;
    assign w_abs_b = w_b[31] ? (~w_b + 32'd1) : w_b;
    assign w_abs_acc = r_acc[rk4_pkg::ACC_W-1] ? (~r_acc + 1'b1) : r_acc;

    // Divide by six: halve, then divide by three with the input split at
    // bit 16 (65535 = 3 * 21845); the low part uses reciprocal 174763 / 2^19
    assign w_half_acc = w_abs_acc[33:1];
    assign w_lo_sum   = 19'(w_half_acc[32:16]) + 19'(w_half_acc[15:0]);
    assign w_lo_prod  = 38'(w_lo_sum) * 38'd174763;
    assign w_q6       = 32'(w_half_acc[32:16]) * 32'd21845 + 32'(w_lo_prod[37:19]);

    assign w_rem_sh = {r_rem, r_num[DW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_out_load = (r_state == rk4_pkg::ST_DONE) && (!r_out_valid || o_res.ready);

    assign i_cmd.ready = (r_state == rk4_pkg::ST_IDLE);

    // Next state and write-back
    always_comb begin
        n_state = r_state;
        w_wen   = 1'b0;
        w_wval  = w_sum.val;
        w_ovf   = 1'b0;
        unique case (r_state)
            rk4_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_cmd.command == rk4_pkg::CMD_STEP) ? rk4_pkg::ST_FETCH
                                                                    : rk4_pkg::ST_DONE;
                end
            end
            rk4_pkg::ST_FETCH: n_state = rk4_pkg::ST_EXEC;
            rk4_pkg::ST_EXEC: begin
                unique case (w_ins.op)
                    rk4_pkg::OP_ADD:  begin w_wen = 1'b1; w_wval = w_sum.val; w_ovf = w_sum.ovf; end
                    rk4_pkg::OP_SUB:  begin w_wen = 1'b1; w_wval = w_dif.val; w_ovf = w_dif.ovf; end
                    rk4_pkg::OP_HALF: begin w_wen = 1'b1; w_wval = {w_a[31], w_a[31:1]}; end
                    rk4_pkg::OP_MUL:  n_state = rk4_pkg::ST_MULW;
                    rk4_pkg::OP_DIV: begin
                        if (w_b == '0) begin
                            // Zero divisor: signed full scale or zero
                            w_wen  = 1'b1;
                            w_ovf  = 1'b1;
                            w_wval = w_a[31] ? 32'h8000_0000
                                   : ((w_a == '0) ? 32'h0 : 32'h7FFF_FFFF);
                        end else begin
                            n_state = rk4_pkg::ST_DIVRUN;
                        end
                    end
                    rk4_pkg::OP_DIV6: n_state = rk4_pkg::ST_DIVEND;
                    rk4_pkg::OP_ACCSET, rk4_pkg::OP_ACC2: w_wen = 1'b0;
                endcase
                if (n_state == rk4_pkg::ST_EXEC) begin
                    n_state = (r_pc == rk4_pkg::PC_LAST) ? rk4_pkg::ST_DONE : rk4_pkg::ST_FETCH;
                end
            end
            rk4_pkg::ST_MULW: begin
                w_wen   = 1'b1;
                w_wval  = w_mulr.val;
                w_ovf   = w_mulr.ovf;
                n_state = (r_pc == rk4_pkg::PC_LAST) ? rk4_pkg::ST_DONE : rk4_pkg::ST_FETCH;
            end
            rk4_pkg::ST_DIVRUN: begin
                if (r_cnt == CW'(1)) n_state = rk4_pkg::ST_DIVEND;
            end
            rk4_pkg::ST_DIVEND: begin
                w_wen = 1'b1;
                if (r_neg) begin
                    if (r_num > DW'(33'h0_8000_0000)) begin
                        w_wval = 32'h8000_0000; w_ovf = 1'b1;
                    end else begin
                        w_wval = ~r_num[31:0] + 32'd1;
                    end
                end else if (r_num > DW'(33'h0_7FFF_FFFF)) begin
                    w_wval = 32'h7FFF_FFFF; w_ovf = 1'b1;
                end else begin
                    w_wval = r_num[31:0];
                end
                n_state = (r_pc == rk4_pkg::PC_LAST) ? rk4_pkg::ST_DONE : rk4_pkg::ST_FETCH;
            end
            rk4_pkg::ST_DONE: begin
                if (w_out_load) n_state = rk4_pkg::ST_IDLE;
            end
            default: n_state = rk4_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rk4_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Architectural state, time and error flag
    always_ff @(posedge i_clk) begin
        logic [31:0] t_next;
        t_next = {1'b0, r_time} + {1'b0, r_h};
        if (!i_rst_n) begin
            r_n    <= '0;
            r_s    <= '0;
            r_time <= '0;
            r_err  <= 1'b0;
            r_pc   <= '0;
        end else begin
            if (w_accept) begin
                r_err <= 1'b0;
                r_pc  <= '0;
                if (i_cmd.command == rk4_pkg::CMD_STEP) begin
                    r_time <= t_next[31] ? 31'h7FFF_FFFF : t_next[30:0];
                end else begin
                    r_n    <= i_cmd.init_n;
                    r_s    <= i_cmd.init_s;
                    r_time <= '0;
                end
            end
            if (w_wen) begin
                if (w_ovf) r_err <= 1'b1;
                if (w_ins.dst == rk4_pkg::S_N) r_n <= w_wval;
                if (w_ins.dst == rk4_pkg::S_S) r_s <= w_wval;
                r_pc <= r_pc + 1'b1;
            end else if (r_state == rk4_pkg::ST_EXEC &&
                         (w_ins.op == rk4_pkg::OP_ACCSET || w_ins.op == rk4_pkg::OP_ACC2)) begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    // Multiplier, accumulator and bit-serial divider
    always_ff @(posedge i_clk) begin
        if (r_state == rk4_pkg::ST_EXEC) begin
            r_prod <= w_a64 * w_b64;
            if (w_ins.op == rk4_pkg::OP_ACCSET) r_acc <= w_pair;
            if (w_ins.op == rk4_pkg::OP_ACC2)   r_acc <= r_acc + (w_pair <<< 1);
            r_rem <= '0;
            r_cnt <= CW'(DW);
            if (w_ins.op == rk4_pkg::OP_DIV6) begin
                r_num <= DW'(w_q6);
                r_neg <= r_acc[rk4_pkg::ACC_W-1];
            end else begin
                r_num <= {w_abs_a, {FRAC_BITS{1'b0}}};
                r_den <= w_abs_b;
                r_neg <= w_a[31] ^ w_b[31];
            end
        end else if (r_state == rk4_pkg::ST_DIVRUN) begin
            r_rem <= w_ge ? 32'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[31:0];
            r_num <= {r_num[DW-2:0], w_ge};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_time <= r_time;
            r_out_n    <= r_n;
            r_out_s    <= r_s;
            r_out_err  <= r_err;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.time_now   = r_out_time;
    assign o_res.n_out      = r_out_n;
    assign o_res.s_out      = r_out_s;
    assign o_res.math_error = r_out_err;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != rk4_pkg::ST_IDLE)
        else $error("accepted command did not start work");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rk4_pkg::ST_FETCH |-> r_pc <= rk4_pkg::PC_LAST)
        else $error("microcode pc out of range");
    a_load_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.command == rk4_pkg::CMD_LOAD) |=> (r_time == '0 && !r_err))
        else $error("load did not clear time and error");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rk4_pkg::ST_DIVRUN |-> r_cnt != '0)
        else $error("divider count underflow");
`endif

endmodule
`default_nettype wire

[tb/tb_rk4_two_species_ode_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rk4_two_species_ode_step_unit
// Self-checking bench for the RK4 two-species stepper. Load and step
// commands go in through the command channel. The integration constants
// start at their reset values and are then programmed over APB between
// phases: all at maximum, all at minimum and random values. A local
// fixed-point RK4 model predicts each result, and the result channel is
// checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rk4_two_species_ode_step_unit;
    import rk4_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        cmd;
        logic [31:0] n;
        logic [31:0] s;
    } cmd_item_t;

    typedef struct packed {
        logic [30:0] t;
        logic [31:0] n;
        logic [31:0] s;
        logic        e;
    } ode_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rk4_cmd_if cmd_if ();
    rk4_res_if res_if ();

    rk4_two_species_ode_step_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    cmd_item_t   pending_cmds[$];
    ode_result_t expected_results[$];
    logic [30:0] coef[NUM_CFG];
    logic signed [31:0] n_model, s_model;
    logic [30:0] time_model;
    logic        err_acc;
    int          errors = 0;
    int          n_loads = 0, n_steps = 0, n_results = 0, n_flagged = 0;
    bit          cmd_taken = 0;
    bit          no_idle = 0;

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_LOAD;
        cmd_if.init_n = '0;
        cmd_if.init_s = '0;
        res_if.ready = 1'b0;
    end

    // ---------------- fixed-point model ----------------
    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) begin
            err_acc = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            err_acc = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] f_add(logic signed [31:0] a, logic signed [31:0] b);
        return sat32(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] f_sub(logic signed [31:0] a, logic signed [31:0] b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    function automatic logic signed [31:0] f_mul(logic signed [31:0] a, logic signed [31:0] b);
        return sat32((longint'(a) * longint'(b)) >>> FRAC);
    endfunction

    function automatic logic signed [31:0] f_div(logic signed [31:0] a, logic signed [31:0] b);
        if (b == 0) begin
            err_acc = 1'b1;
            return (a > 0) ? 32'sh7FFF_FFFF : ((a < 0) ? 32'sh8000_0000 : 32'sd0);
        end
        return sat32((longint'(a) <<< FRAC) / longint'(b));
    endfunction

    function automatic logic signed [31:0] c(logic [2:0] idx);
        return $signed({1'b0, coef[idx]});
    endfunction

    function automatic logic signed [31:0] dn_dt(logic signed [31:0] n, logic signed [31:0] s);
        return f_sub(f_div(s, f_add(c(REG_KS), s)), n);
    endfunction

    function automatic logic signed [31:0] ds_dt(logic signed [31:0] n, logic signed [31:0] s);
        logic signed [31:0] one, prod, up, down;
        one = 32'sd1 <<< FRAC;
        prod = f_add(c(REG_ALPHA), f_mul(c(REG_LAM), n));
        up = f_div(f_mul(prod, f_sub(one, s)), f_sub(f_add(c(REG_KI), one), s));
        down = f_div(f_mul(c(REG_MU), s), f_add(c(REG_KA), s));
        return f_sub(up, down);
    endfunction

    function automatic logic signed [31:0] rk_update(logic signed [31:0] x,
        logic signed [31:0] k1, logic signed [31:0] k2, logic signed [31:0] k3,
        logic signed [31:0] k4);
        longint sum;
        logic signed [31:0] avg;
        sum = longint'(k1) + 2 * longint'(k2) + 2 * longint'(k3) + longint'(k4);
        avg = 32'(sum / 6);
        return f_add(x, f_mul(c(REG_H), avg));
    endfunction

    function automatic ode_result_t predict_ode(cmd_item_t it);
        ode_result_t r;
        logic signed [31:0] h, k1n, k1s, k2n, k2s, k3n, k3s, k4n, k4s, pn, ps;
        logic [31:0] t;
        err_acc = 1'b0;
        if (it.cmd == CMD_LOAD) begin
            n_model = it.n;
            s_model = it.s;
            time_model = '0;
        end else begin
            h = c(REG_H);
            k1n = dn_dt(n_model, s_model);
            k1s = ds_dt(n_model, s_model);
            pn = f_add(n_model, f_mul(h, k1n) >>> 1);
            ps = f_add(s_model, f_mul(h, k1s) >>> 1);
            k2n = dn_dt(pn, ps);
            k2s = ds_dt(pn, ps);
            pn = f_add(n_model, f_mul(h, k2n) >>> 1);
            ps = f_add(s_model, f_mul(h, k2s) >>> 1);
            k3n = dn_dt(pn, ps);
            k3s = ds_dt(pn, ps);
            pn = f_add(n_model, f_mul(h, k3n));
            ps = f_add(s_model, f_mul(h, k3s));
            k4n = dn_dt(pn, ps);
            k4s = ds_dt(pn, ps);
            n_model = rk_update(n_model, k1n, k2n, k3n, k4n);
            s_model = rk_update(s_model, k1s, k2s, k3s, k4s);
            t = {1'b0, time_model} + {1'b0, coef[REG_H]};
            time_model = t[31] ? MAX31 : t[30:0];
        end
        r.t = time_model;
        r.n = n_model;
        r.s = s_model;
        r.e = err_acc;
        return r;
    endfunction

    // ---------------- mismatch reporting ----------------
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // ---------------- command driver ----------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!cmd_if.valid || cmd_taken)) begin
            cmd_taken = 0;
            if (pending_cmds.size() == 0 || (!no_idle && $urandom_range(99) < 7)) begin
                cmd_if.valid <= 1'b0;
            end else begin
                cmd_item_t it;
                it = pending_cmds.pop_front();
                cmd_if.valid <= 1'b1;
                cmd_if.command <= it.cmd;
                cmd_if.init_n <= it.n;
                cmd_if.init_s <= it.s;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= i_rst_n && (no_idle || $urandom_range(99) >= 7);
    end

    // ---------------- monitors ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            cmd_item_t it;
            it.cmd = cmd_if.command;
            it.n = cmd_if.init_n;
            it.s = cmd_if.init_s;
            if (it.cmd == CMD_LOAD) n_loads++;
            else n_steps++;
            expected_results.insert(expected_results.size(), predict_ode(it));
            cmd_taken = 1;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            if (res_if.math_error) n_flagged++;
            if (expected_results.size() == 0) begin
                report("unexpected transaction", res_if.n_out, '0);
            end else begin
                ode_result_t w;
                w = expected_results.pop_front();
                if (res_if.time_now !== w.t) report("time_now", {1'b0, res_if.time_now}, {1'b0, w.t});
                if (res_if.n_out !== w.n) report("n_out", res_if.n_out, w.n);
                if (res_if.s_out !== w.s) report("s_out", res_if.s_out, w.s);
                if (res_if.math_error !== w.e) report("math_error", 32'(res_if.math_error), 32'(w.e));
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        coef[idx] = val[30:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic push_cmd(logic cmd, logic [31:0] n, logic [31:0] s);
        cmd_item_t it;
        it.cmd = cmd; it.n = n; it.s = s;
        pending_cmds.insert(pending_cmds.size(), it);
    endtask

    // wait on clock edges until nothing is queued, driven or outstanding
    task automatic drain;
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // small Q8.24 value most of the time, full range now and then
    function automatic logic [31:0] rand_val();
        if ($urandom_range(9) < 8) return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(9) < 7) return $urandom_range(0, 32'h0400_0000);
        return $urandom;
    endfunction

    task automatic random_sequences(int count);
        int k;
        k = 0;
        while (k < count) begin
            if ($urandom_range(9) == 0) begin
                push_cmd(CMD_STEP, $urandom, $urandom);
                k++;
            end else begin
                int steps;
                steps = $urandom_range(1, 6);
                push_cmd(CMD_LOAD, rand_val(), rand_val());
                repeat (steps) push_cmd(CMD_STEP, $urandom, $urandom);
                k += steps + 1;
            end
        end
    endtask

    // ---------------- test sequence ----------------
    initial begin
        coef[REG_KA] = RST_KA; coef[REG_KI] = RST_KI; coef[REG_KS] = RST_KS;
        coef[REG_ALPHA] = RST_ALPHA; coef[REG_MU] = RST_MU; coef[REG_LAM] = RST_LAM;
        coef[REG_H] = RST_H;
        n_model = '0; s_model = '0; time_model = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset constants, extremes and zero divisors
        push_cmd(CMD_STEP, '0, '0);
        push_cmd(CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_cmd(CMD_STEP, '0, '0);
        push_cmd(CMD_LOAD, 32'h8000_0000, 32'h8000_0000);
        push_cmd(CMD_STEP, '0, '0);
        push_cmd(CMD_LOAD, 32'hFE00_0000, 32'h0100_0000);   // 1 - s = 0
        push_cmd(CMD_STEP, '0, '0);
        push_cmd(CMD_LOAD, 32'h0100_0000, 32'h0200_0000);   // ki + 1 - s = 0
        push_cmd(CMD_STEP, '0, '0);
        push_cmd(CMD_LOAD, 32'h0000_0000, 32'hFF00_0000);   // ka + s = 0
        push_cmd(CMD_STEP, '0, '0);
        push_cmd(CMD_LOAD, 32'h0080_0000, 32'h0040_0000);
        repeat (4) push_cmd(CMD_STEP, $urandom, $urandom);
        drain();

        // time saturation with the largest step
        apb_write(REG_H, 32'h7FFF_FFFF);
        push_cmd(CMD_LOAD, '0, '0);
        repeat (3) push_cmd(CMD_STEP, '0, '0);
        drain();
        apb_write(REG_H, RST_H);

        // random items with the reset constants, then a stretch without idling
        random_sequences(150);
        drain();
        no_idle = 1;
        random_sequences(100);
        drain();
        no_idle = 0;

        // all constants at maximum
        for (int i = 0; i < NUM_CFG; i++) apb_write(3'(i), 32'hFFFF_FFFF);
        random_sequences(40);
        drain();

        // all constants at minimum
        for (int i = 0; i < NUM_CFG - 1; i++) apb_write(3'(i), '0);
        apb_write(REG_H, 32'd1);
        push_cmd(CMD_LOAD, '0, '0);
        push_cmd(CMD_STEP, '0, '0);
        random_sequences(40);
        drain();

        // several random settings
        repeat (4) begin
            for (int i = 0; i < NUM_CFG - 1; i++) apb_write(3'(i), rand_coef());
            apb_write(REG_H, 32'($urandom_range(1, 32'h0100_0000)));
            random_sequences(60);
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("covered %0d loads and %0d steps, %0d results (%0d flagged)",
                 n_loads, n_steps, n_results, n_flagged);
        $display("constants: reset, maximum, minimum and four random settings");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[rk4_two_species_ode_step_unit] OK");
        end else begin
            $display("[rk4_two_species_ode_step_unit] ERROR");
        end
        $finish;
    end

    // run time limit
    initial begin
        #40_000_000;
        $display("[rk4_two_species_ode_step_unit] ERROR");
        $finish;
    end

endmodule
